### rtl/framebuffer_page_entry_builder_macros.svh
// Assertion macros used by the top RTL file of the page-entry builder.
`ifndef FRAMEBUFFER_PAGE_ENTRY_BUILDER_MACROS_SVH
`define FRAMEBUFFER_PAGE_ENTRY_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPEB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpeb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPEB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpeb assertion failed");

`endif

### rtl/fpeb_pkg.sv
package fpeb_pkg;

	localparam int unsigned DirectoryDepth = 512;

	localparam logic [63:0] LeafFlags  = 64'h8000_0000_0000_0113;
	localparam logic [63:0] LargeBit   = 64'h0000_0000_0000_0080;
	localparam logic [63:0] TableFlags = 64'h0000_0000_0000_0003;
	localparam logic [63:0] TopLimit   = 64'hFFFF_FFFF_FFFF_F000;
	localparam logic [43:0] DepthCount = 44'(DirectoryDepth);

	localparam int unsigned SettleW = 3;
	localparam logic [SettleW-1:0] SettleCycles = 3'd4;

	typedef enum logic [2:0] {
		RegRangeBase     = 3'd0,
		RegRangeSize     = 3'd1,
		RegPhysicalLimit = 3'd2,
		RegEdge0Address  = 3'd3,
		RegEdge1Address  = 3'd4,
		RegDirCapacity   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        kind;
		logic [8:0]  directory_index;
		logic        edge_select;
		logic [8:0]  slot_index;
	} query_t;

	typedef struct packed {
		logic        accepted;
		logic [9:0]  chunk_count;
		logic        entry_written;
		logic [63:0] entry_value;
	} result_t;

	typedef struct packed {
		logic [63:0] range_base;
		logic [63:0] range_size;
		logic [63:0] physical_limit;
		logic [63:0] edge0_address;
		logic [63:0] edge1_address;
		logic [9:0]  directory_capacity;
	} cfg_t;

	typedef struct packed {
		logic        accept;
		logic [9:0]  cnt;
		logic [9:0]  cnt_m1;
		logic        head_part;
		logic        tail_part;
		logic        p0;
		logic        pl;
		logic [42:0] aligned_hi;
		logic [42:0] last_hi;
		logic [51:0] first_pg;
		logic [51:0] end_pg;
		logic [63:0] edge0;
		logic [63:0] edge1;
	} geom_t;

endpackage

### rtl/fpeb_query_if.sv
interface fpeb_query_if;
	logic             valid;
	logic             ready;
	fpeb_pkg::query_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/fpeb_result_if.sv
interface fpeb_result_if;
	logic              valid;
	logic              ready;
	fpeb_pkg::result_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/fpeb_geom.sv
module fpeb_geom (
	input  logic            clk,
	input  fpeb_pkg::cfg_t  cfg,
	output fpeb_pkg::geom_t geom
);

	logic [64:0] sum_s1;
	logic        size_zero_s1;
	logic        base_over_s1;
	logic [63:0] lim_gap_s1;
	logic [63:0] size_m1_s1;
	logic        edges_ok_s1;

	logic        rng_ok_s2;
	logic        edges_ok_s2;
	logic [51:0] end_pg_s2;
	logic [43:0] ceil_hi_s2;

	logic        ok_s3;
	logic [43:0] count_s3;
	logic [43:0] last_hi_s3;
	logic        ep_s3;
	logic [51:0] end_pg_s3;

	logic        accept_s4;
	logic [9:0]  cnt_s4;
	logic [9:0]  cnt_m1_s4;
	logic        head_s4;
	logic        ep_s4;
	logic        p0_s4;
	logic        pl_s4;
	logic [42:0] last_hi_s4;
	logic [51:0] end_pg_s4;

	logic        head_part;

	assign head_part = cfg.range_base[20:12] != 9'd0;

	always_ff @(posedge clk) begin
		sum_s1       <= {1'b0, cfg.range_base} + {1'b0, cfg.range_size};
		size_zero_s1 <= cfg.range_size == 64'd0;
		base_over_s1 <= cfg.range_base > cfg.physical_limit;
		lim_gap_s1   <= cfg.physical_limit - cfg.range_base;
		size_m1_s1   <= cfg.range_size - 64'd1;
		edges_ok_s1  <= (cfg.edge0_address[11:0] == 12'd0)
			&& ((cfg.edge0_address | 64'hFFF) <= cfg.physical_limit)
			&& (cfg.edge1_address[11:0] == 12'd0)
			&& ((cfg.edge1_address | 64'hFFF) <= cfg.physical_limit);
	end

	always_ff @(posedge clk) begin
		rng_ok_s2   <= !size_zero_s1 && !base_over_s1 && !(size_m1_s1 > lim_gap_s1)
			&& !sum_s1[64] && !(sum_s1[63:0] > fpeb_pkg::TopLimit);
		edges_ok_s2 <= edges_ok_s1;
		end_pg_s2   <= sum_s1[63:12] + {51'd0, sum_s1[11:0] != 12'd0};
		ceil_hi_s2  <= {1'b0, sum_s1[63:21]} + {43'd0, sum_s1[20:0] != 21'd0};
	end

	always_ff @(posedge clk) begin
		ok_s3      <= rng_ok_s2 && edges_ok_s2;
		count_s3   <= ceil_hi_s2 - {1'b0, cfg.range_base[63:21]};
		last_hi_s3 <= ceil_hi_s2 - 44'd1;
		ep_s3      <= end_pg_s2[8:0] != 9'd0;
		end_pg_s3  <= end_pg_s2;
	end

	always_ff @(posedge clk) begin
		accept_s4  <= ok_s3 && (count_s3 != 44'd0)
			&& (count_s3 <= {34'd0, cfg.directory_capacity})
			&& (count_s3 <= fpeb_pkg::DepthCount);
		cnt_s4     <= count_s3[9:0];
		cnt_m1_s4  <= count_s3[9:0] - 10'd1;
		head_s4    <= head_part;
		ep_s4      <= ep_s3;
		p0_s4      <= head_part || ((count_s3 == 44'd1) && ep_s3);
		pl_s4      <= (count_s3 >= 44'd2) && ep_s3;
		last_hi_s4 <= last_hi_s3[42:0];
		end_pg_s4  <= end_pg_s3;
	end

	always_comb begin
		geom            = '0;
		geom.accept     = accept_s4;
		geom.cnt        = cnt_s4;
		geom.cnt_m1     = cnt_m1_s4;
		geom.head_part  = head_s4;
		geom.tail_part  = ep_s4;
		geom.p0         = p0_s4;
		geom.pl         = pl_s4;
		geom.aligned_hi = cfg.range_base[63:21];
		geom.last_hi    = last_hi_s4;
		geom.first_pg   = cfg.range_base[63:12];
		geom.end_pg     = end_pg_s4;
		geom.edge0      = cfg.edge0_address;
		geom.edge1      = cfg.edge1_address;
	end

endmodule

### rtl/fpeb_entry.sv
module fpeb_entry (
	input  fpeb_pkg::query_t  query,
	input  fpeb_pkg::geom_t   geom,
	output fpeb_pkg::result_t result
);

	logic [42:0] chunk_hi;
	logic        full_chunk;
	logic        has_edge;
	logic [42:0] echunk_hi;
	logic [51:0] page_pg;

	assign chunk_hi   = geom.aligned_hi + {34'd0, query.directory_index};
	assign full_chunk = !((query.directory_index == 9'd0) && geom.head_part)
		&& !(({1'b0, query.directory_index} == geom.cnt_m1) && geom.tail_part);

	always_comb begin
		has_edge  = 1'b0;
		echunk_hi = geom.aligned_hi;
		if (!query.edge_select) begin
			if (geom.p0) begin
				has_edge = 1'b1;
			end else if (geom.pl) begin
				has_edge  = 1'b1;
				echunk_hi = geom.last_hi;
			end
		end else if (geom.p0 && geom.pl) begin
			has_edge  = 1'b1;
			echunk_hi = geom.last_hi;
		end
	end

	assign page_pg = {echunk_hi, query.slot_index};

	always_comb begin
		result = '0;
		if (geom.accept) begin
			result.accepted    = 1'b1;
			result.chunk_count = geom.cnt;
			if (!query.kind) begin
				if ({1'b0, query.directory_index} < geom.cnt) begin
					result.entry_written = 1'b1;
					if (full_chunk) begin
						result.entry_value = {chunk_hi, 21'd0} | fpeb_pkg::LeafFlags
							| fpeb_pkg::LargeBit;
					end else if ((query.directory_index != 9'd0) && geom.p0) begin
						result.entry_value = geom.edge1 | fpeb_pkg::TableFlags;
					end else begin
						result.entry_value = geom.edge0 | fpeb_pkg::TableFlags;
					end
				end
			end else if (has_edge && (page_pg >= geom.first_pg) && (page_pg < geom.end_pg)) begin
				result.entry_written = 1'b1;
				result.entry_value   = {page_pg, 12'd0} | fpeb_pkg::LeafFlags;
			end
		end
	end

endmodule

### rtl/framebuffer_page_entry_builder.sv
// Channel   Role    Transaction
// query     sink    one page-table query: kind, directory index, edge select, slot
// result    source  one answer: accepted, chunk count, entry written, entry value
// cfg_*     write   one register write per cycle with cfg_write high
//
// Each accepted query passes through the input register and then the result register, and
// one query is taken every cycle unless the result stalls or the geometry is settling.
// The range geometry is worked out over four pipeline stages after every register write
// and after reset, and queries are held off until the settle counter has run down.
// A stalled result holds the result register, and a query still enters while the input
// register is empty or drains into it.
`include "framebuffer_page_entry_builder_macros.svh"

module framebuffer_page_entry_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	fpeb_query_if.sink  query,
	fpeb_result_if.source result
);

	fpeb_pkg::cfg_t                   cfg_q;
	logic [fpeb_pkg::SettleW-1:0]     settle_q;
	fpeb_pkg::geom_t                  geom;

	logic                             valid_s1;
	fpeb_pkg::query_t                 query_s1;
	logic                             valid_s2;
	fpeb_pkg::result_t                result_s2;
	fpeb_pkg::result_t                result_calc;

	logic                             out_free;
	logic                             in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				fpeb_pkg::RegRangeBase:     cfg_q.range_base         <= cfg_data;
				fpeb_pkg::RegRangeSize:     cfg_q.range_size         <= cfg_data;
				fpeb_pkg::RegPhysicalLimit: cfg_q.physical_limit     <= cfg_data;
				fpeb_pkg::RegEdge0Address:  cfg_q.edge0_address      <= cfg_data;
				fpeb_pkg::RegEdge1Address:  cfg_q.edge1_address      <= cfg_data;
				fpeb_pkg::RegDirCapacity:   cfg_q.directory_capacity <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= fpeb_pkg::SettleCycles;
		end else if (cfg_write) begin
			settle_q <= fpeb_pkg::SettleCycles;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	fpeb_geom u_geom (
		.clk  (clk),
		.cfg  (cfg_q),
		.geom (geom)
	);

	assign out_free    = !valid_s2 || result.ready;
	assign query.ready = (settle_q == '0) && (!valid_s1 || out_free);
	assign in_take     = query.valid && query.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			query_s1 <= query.payload;
		end
	end

	fpeb_entry u_entry (
		.query  (query_s1),
		.geom   (geom),
		.result (result_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			result_s2 <= result_calc;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = result_s2;

	`FPEB_ASSERT_NOW(a_settle_blocks, settle_q != '0, !query.ready)
	`FPEB_ASSERT_NEXT(a_write_restarts, cfg_write, settle_q == fpeb_pkg::SettleCycles)
	`FPEB_ASSERT_NEXT(a_s1_holds, valid_s1 && !out_free, valid_s1 && $stable(query_s1))
	`FPEB_ASSERT_NOW(a_written_needs_ok, valid_s2 && result_s2.entry_written, result_s2.accepted)

endmodule
